### rtl/fdmd_pkg.sv
// fdmd_pkg: shared constants, types and helpers of the frame difference motion detector
// no dependencies; used by the reference store, the top level and the testbench
`default_nettype none

package fdmd_pkg;

  // store geometry and sampling
  localparam int STORE_DEPTH   = 32768;
  localparam int SAMPLE_STRIDE = 10;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int SIDX_W        = $clog2(STORE_DEPTH + 1);
  localparam int PHASE_W       = 4;
  localparam int PIX_W         = 8;
  localparam int CNT_OUT_W     = 16;

  // configuration register indexes and reset values
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGE_PCT = 8'd1;
  localparam logic [7:0] THRESHOLD_RESET = 8'd50;
  localparam logic [6:0] PERCENT_RESET   = 7'd5;
  localparam logic [6:0] PERCENT_SCALE   = 7'd100;

  // reciprocal of three: x/3 == (x*683)>>11 for every x below 1536
  localparam logic [9:0] RECIP3     = 10'd683;
  localparam int         RECIP3_SH  = 11;

  // write request into the reference store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } store_wr_t;

  // gray value floor((b+g+r)/3)
  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] r);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(b) + 10'(g) + 10'(r);
    prod = 20'(sum) * 20'(RECIP3);
    return prod[RECIP3_SH +: PIX_W];
  endfunction

endpackage

`default_nettype wire

### rtl/fdmd_ref_store.sv
// fdmd_ref_store: one-port-read, one-port-write gray reference memory
// depends on fdmd_pkg for geometry and the write request struct
`default_nettype none

module fdmd_ref_store (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [fdmd_pkg::ADDR_W-1:0]   rd_addr,
  output logic      [fdmd_pkg::PIX_W-1:0]    rd_data,
  input  wire fdmd_pkg::store_wr_t           wr
);

  logic [fdmd_pkg::PIX_W-1:0] mem [fdmd_pkg::STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/frame_difference_motion_detect.sv
// frame_difference_motion_detect: one pixel per cycle sustained; out_valid is registered
// and rises when the frame end pixel leaves the compare stage. The store read is
// issued at the input transfer, the compare and write-back follow when the compare stage
// advances; input stalls only while a frame end result waits on a full output.
// A fill count from slot zero plus one written range begun by a clear in mid frame
// mark which store entries were written since reset or the last clear, so neither reset
// nor clear sweeps the memory.
// Synchronous active-low reset clears counters, fill tracking, pipeline and output valid.
`default_nettype none

module frame_difference_motion_detect (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // pixel channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_action,
  input  wire logic [7:0]                       in_blue,
  input  wire logic [7:0]                       in_green,
  input  wire logic [7:0]                       in_red,
  input  wire logic                             in_frame_end,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_motion,
  output logic [15:0]                           out_changed_samples,
  output logic [15:0]                           out_sampled_count,
  // configuration channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fdmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  localparam int AW = fdmd_pkg::ADDR_W;
  localparam int SW = fdmd_pkg::SIDX_W;
  localparam int PW = fdmd_pkg::PHASE_W;
  localparam int XW = fdmd_pkg::PIX_W;

  // configuration registers
  logic [7:0] thr_r;
  logic [6:0] pct_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= fdmd_pkg::THRESHOLD_RESET;
      pct_r <= fdmd_pkg::PERCENT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fdmd_pkg::CFG_DIFF_THRESHOLD: thr_r <= cfg_data;
        fdmd_pkg::CFG_MIN_CHANGE_PCT: pct_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // frame state and pipeline registers
  logic [PW-1:0] phase_r, phase_nxt;
  logic [SW-1:0] sidx_r, sidx_nxt;
  logic [SW-1:0] fill_r, fill_nxt;
  logic [SW-1:0] seg_lo_r, seg_lo_nxt;
  logic [SW-1:0] seg_hi_r, seg_hi_nxt;
  logic [SW-1:0] chg_r, chg_nxt;

  logic          b_valid_r, b_last_r, b_sample_r, b_ref_ok_r, b_fwd_r;
  logic [AW-1:0] b_addr_r;
  logic [XW-1:0] b_gray_r, b_fwd_gray_r;
  logic [SW-1:0] b_count_r;

  logic          out_valid_r;
  logic [SW-1:0] out_changed_r, out_sampled_r;

  // stage advance and input handshake
  logic b_go, in_xfer, pixel, take;
  logic [SW-1:0] sidx_inc;
  logic [AW-1:0] a_addr;
  logic [XW-1:0] a_gray;

  assign b_go     = b_valid_r && !(b_last_r && out_valid_r && !out_ready);
  assign in_ready = !b_valid_r || b_go;
  assign in_xfer  = in_valid && in_ready;
  assign pixel    = in_xfer && !in_action;
  assign take     = pixel && (phase_r == '0) && (sidx_r < SW'(fdmd_pkg::STORE_DEPTH));
  assign sidx_inc = sidx_r + SW'(take);
  assign a_addr   = sidx_r[AW-1:0];
  assign a_gray   = fdmd_pkg::gray_of(in_blue, in_green, in_red);

  // memory
  logic [XW-1:0]       rd_data;
  fdmd_pkg::store_wr_t wr;

  assign wr.en   = b_go && b_sample_r;
  assign wr.addr = b_addr_r;
  assign wr.data = b_gray_r;

  fdmd_ref_store u_store (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (a_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // phase, sample index and fill tracking update at the input transfer
  // a clear in mid frame opens a written range at the current slot
  always_comb begin
    phase_nxt  = phase_r;
    sidx_nxt   = sidx_r;
    fill_nxt   = fill_r;
    seg_lo_nxt = seg_lo_r;
    seg_hi_nxt = seg_hi_r;
    if (in_xfer && in_action) begin
      fill_nxt   = '0;
      seg_lo_nxt = sidx_r;
      seg_hi_nxt = sidx_r;
    end else if (pixel) begin
      if (take && (sidx_r == fill_r)) begin
        fill_nxt = fill_r + SW'(1);
      end else if (take && (sidx_r == seg_hi_r)) begin
        seg_hi_nxt = seg_hi_r + SW'(1);
      end
      if (in_frame_end) begin
        phase_nxt = '0;
        sidx_nxt  = '0;
      end else begin
        phase_nxt = (phase_r == PW'(fdmd_pkg::SAMPLE_STRIDE - 1)) ? '0 : phase_r + PW'(1);
        sidx_nxt  = sidx_inc;
      end
    end
  end

  // compare stage: forwarded or stored reference against the new gray
  logic [XW-1:0] ref_val, diff;
  logic          changed;
  logic [SW-1:0] chg_inc;

  always_comb begin
    ref_val = b_fwd_r ? b_fwd_gray_r : rd_data;
    diff    = (b_gray_r > ref_val) ? (b_gray_r - ref_val) : (ref_val - b_gray_r);
    changed = b_sample_r && b_ref_ok_r && (ref_val != '0) && (diff > thr_r);
    chg_inc = chg_r + SW'(changed);
    chg_nxt = chg_r;
    if (b_go) begin
      chg_nxt = b_last_r ? '0 : chg_inc;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      sidx_r      <= '0;
      fill_r      <= '0;
      seg_lo_r    <= '0;
      seg_hi_r    <= '0;
      chg_r       <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      sidx_r   <= sidx_nxt;
      fill_r   <= fill_nxt;
      seg_lo_r <= seg_lo_nxt;
      seg_hi_r <= seg_hi_nxt;
      chg_r    <= chg_nxt;
      if (pixel) begin
        b_valid_r <= 1'b1;
      end else if (b_go) begin
        b_valid_r <= 1'b0;
      end
      if (b_go && b_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (pixel) begin
      b_last_r     <= in_frame_end;
      b_sample_r   <= take;
      b_addr_r     <= a_addr;
      b_gray_r     <= a_gray;
      b_ref_ok_r   <= (sidx_r < fill_r) || ((sidx_r >= seg_lo_r) && (sidx_r < seg_hi_r));
      b_fwd_r      <= b_valid_r && b_sample_r && (b_addr_r == a_addr);
      b_fwd_gray_r <= b_gray_r;
      b_count_r    <= sidx_inc;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (b_go && b_last_r) begin
      out_changed_r <= chg_inc;
      out_sampled_r <= b_count_r;
    end
  end

  // motion test: changed*100 > percent*sampled
  logic [SW+6:0] lhs, rhs;

  assign lhs = (SW+7)'(out_changed_r) * (SW+7)'(fdmd_pkg::PERCENT_SCALE);
  assign rhs = (SW+7)'(pct_r) * (SW+7)'(out_sampled_r);

  assign out_valid           = out_valid_r;
  assign out_motion          = lhs > rhs;
  assign out_changed_samples = fdmd_pkg::CNT_OUT_W'(out_changed_r);
  assign out_sampled_count   = fdmd_pkg::CNT_OUT_W'(out_sampled_r);

endmodule

`default_nettype wire

### rtl/fdmd_checker.sv
// fdmd_checker: port-level assertions on the result channel of the motion detector
// bound to frame_difference_motion_detect; no package dependency
`default_nettype none

module fdmd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_motion,
  input wire logic [15:0] out_changed_samples,
  input wire logic [15:0] out_sampled_count
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_changed_samples)
      && $stable(out_sampled_count))
    else $error("result changed while stalled");

  // changed samples never exceed samples taken
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_changed_samples <= out_sampled_count)
    else $error("changed count above sampled count");

  // motion needs at least one changed sample
  a_motion_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motion |-> out_changed_samples != 16'd0)
    else $error("motion flagged with no changed samples");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_difference_motion_detect fdmd_checker u_fdmd_checker (.*);

`default_nettype wire

### dv/tb_top.sv
// tb_top: self-checking testbench for the frame difference motion detector
// depends on rtl/fdmd_pkg.sv and rtl/frame_difference_motion_detect.sv;
// predicts per-frame reports from its own copy of the reference store

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH   = fdmd_pkg::STORE_DEPTH;
  localparam int STRIDE        = fdmd_pkg::SAMPLE_STRIDE;
  localparam int IDX_W         = fdmd_pkg::CFG_IDX_W;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 950;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = fdmd_pkg::CFG_DIFF_THRESHOLD;
  localparam logic [IDX_W-1:0] REG_PERCENT   = fdmd_pkg::CFG_MIN_CHANGE_PCT;
  localparam logic [IDX_W-1:0] REG_UNMAPPED  = '1;

  typedef struct packed {
    logic        motion;
    logic [15:0] changed;
    logic [15:0] sampled;
  } frame_report_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic             in_action    = 1'b0;
  logic [7:0]       in_blue      = 8'd0;
  logic [7:0]       in_green     = 8'd0;
  logic [7:0]       in_red       = 8'd0;
  logic             in_frame_end = 1'b0;
  logic             out_valid;
  logic             out_ready    = 1'b1;
  logic             out_motion;
  logic [15:0]      out_changed_samples;
  logic [15:0]      out_sampled_count;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index    = '0;
  logic [7:0]       cfg_data     = 8'd0;

  frame_difference_motion_detect dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_blue             (in_blue),
    .in_green            (in_green),
    .in_red              (in_red),
    .in_frame_end        (in_frame_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_motion          (out_motion),
    .out_changed_samples (out_changed_samples),
    .out_sampled_count   (out_sampled_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // predictor state: gray history per sample slot, frame counters, registers
  logic [7:0]    gray_ref [STORE_DEPTH];
  int unsigned   stride_pos = 0;
  int unsigned   sample_cnt = 0;
  int unsigned   change_cnt = 0;
  logic [7:0]    thr_reg    = fdmd_pkg::THRESHOLD_RESET;
  logic [6:0]    pct_reg    = fdmd_pkg::PERCENT_RESET;
  frame_report_t expected_reports[$];

  int unsigned items_sent      = 0;
  int unsigned mismatches      = 0;
  int unsigned ready_hold      = 0;
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;

  task automatic clear_gray_ref();
    for (int i = 0; i < STORE_DEPTH; i++) gray_ref[i] = 8'd0;
  endtask

  // advance the predictor by one accepted transfer
  task automatic predict_frame_stats(input logic act, input logic [7:0] b, g, r,
                                     input logic last);
    int unsigned   gray;
    int unsigned   diff;
    frame_report_t rpt;
    if (act == ACT_CLEAR) begin
      clear_gray_ref();
      return;
    end
    // sampled pixel: compare against the stored gray, then replace it
    if (stride_pos == 0 && sample_cnt < STORE_DEPTH) begin
      gray = (32'(b) + 32'(g) + 32'(r)) / 3;
      if (gray_ref[sample_cnt] != 8'd0) begin
        diff = (gray > gray_ref[sample_cnt]) ? gray - gray_ref[sample_cnt]
                                             : gray_ref[sample_cnt] - gray;
        if (diff > thr_reg) change_cnt++;
      end
      gray_ref[sample_cnt] = 8'(gray);
      sample_cnt++;
    end
    stride_pos = (stride_pos + 1 >= STRIDE) ? 0 : stride_pos + 1;
    // frame end: queue the report and restart the counters
    if (last) begin
      rpt.motion  = (64'(change_cnt) * 64'(fdmd_pkg::PERCENT_SCALE))
                    > (64'(pct_reg) * 64'(sample_cnt));
      rpt.changed = 16'(change_cnt);
      rpt.sampled = 16'(sample_cnt);
      expected_reports.push_back(rpt);
      stride_pos = 0;
      sample_cnt = 0;
      change_cnt = 0;
    end
  endtask

  // one input transfer, with an optional random gap in front
  task automatic send_item(input logic act, input logic [7:0] b, g, r, input logic last);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_blue      <= b;
    in_green     <= g;
    in_red       <= r;
    in_frame_end <= last;
    do @(posedge clk); while (!in_ready);
    predict_frame_stats(act, b, g, r, last);
    items_sent++;
  endtask

  task automatic send_pixel(input logic [7:0] b, g, r, input logic last);
    send_item(ACT_PIXEL, b, g, r, last);
  endtask

  // clear with junk in the ignored fields
  task automatic send_clear();
    send_item(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // stop sending, let every report arrive and the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_THRESHOLD) thr_reg = data;
    else if (idx == REG_PERCENT) pct_reg = data[6:0];
  endtask

  function automatic logic [7:0] near_value(input int base, input int spread);
    int v;
    v = base - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // frame of random pixels: mostly close to one level, some noise or near-black
  task automatic send_random_frame(input int unsigned n_pix, input bit with_clears);
    int         base;
    int         spread;
    int         style;
    logic [7:0] b, g, r;
    base   = $urandom_range(0, 255);
    spread = ($urandom_range(0, 3) == 0) ? 40 : 4;
    style  = $urandom_range(0, 5);
    for (int unsigned i = 0; i < n_pix; i++) begin
      if (with_clears && $urandom_range(0, 39) == 0) send_clear();
      if (style == 0 || $urandom_range(0, 15) == 0) begin
        {b, g, r} = 24'($urandom);
      end else if (style == 1) begin
        b = 8'($urandom_range(0, 1));
        g = 8'($urandom_range(0, 1));
        r = 8'($urandom_range(0, 1));
      end else begin
        b = near_value(base, spread);
        g = near_value(base, spread);
        r = near_value(base, spread);
      end
      send_pixel(b, g, r, i == n_pix - 1);
    end
  endtask

  // single-pixel frames on the first slot: extremes, zero reference, threshold edge
  task automatic test_first_slot();
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0,   8'd0,   8'd2,   1'b1);
    send_pixel(8'd1,   8'd1,   8'd0,   1'b1);
    send_pixel(8'd100, 8'd100, 8'd100, 1'b1);
    send_pixel(8'd150, 8'd150, 8'd150, 1'b1);
    send_pixel(8'd201, 8'd201, 8'd201, 1'b1);
    send_clear();
    send_pixel(8'd255, 8'd254, 8'd253, 1'b1);
  endtask

  // clear in the middle of a frame keeps the counters and stride position
  task automatic test_clear_mid_frame();
    for (int i = 0; i < 12; i++) begin
      if (i == 5) send_clear();
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 11);
    end
    send_clear();
  endtask

  // register extremes, an oversized percentage and an unmapped index
  task automatic test_config_extremes();
    write_reg(REG_THRESHOLD, 8'd0);
    write_reg(REG_PERCENT, 8'd0);
    send_random_frame(25, 1'b0);
    send_random_frame(25, 1'b0);
    write_reg(REG_THRESHOLD, 8'd255);
    write_reg(REG_PERCENT, 8'd100);
    send_random_frame(25, 1'b0);
    write_reg(REG_THRESHOLD, 8'd1);
    write_reg(REG_PERCENT, 8'hFF);
    write_reg(REG_UNMAPPED, 8'h00);
    send_random_frame(25, 1'b0);
    write_reg(REG_PERCENT, 8'd1);
    send_random_frame(25, 1'b0);
    write_reg(REG_THRESHOLD, fdmd_pkg::THRESHOLD_RESET);
    write_reg(REG_PERCENT, 8'(fdmd_pkg::PERCENT_RESET));
  endtask

  // random frames with occasional register changes between them
  task automatic test_random_frames();
    int unsigned goal;
    int unsigned n_pix;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      sender_gaps     = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_THRESHOLD, 8'd0);
          1:       write_reg(REG_THRESHOLD, 8'd255);
          default: write_reg(REG_THRESHOLD, 8'($urandom_range(0, 60)));
        endcase
        if ($urandom_range(0, 1) != 0) write_reg(REG_PERCENT, 8'($urandom_range(0, 100)));
      end
      n_pix = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 250) : $urandom_range(1, 40);
      send_random_frame(n_pix, 1'b1);
    end
  endtask

  // one long frame sent back to back, then frames around a clear
  task automatic test_long_frame();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    write_reg(REG_THRESHOLD, 8'd3);
    send_random_frame(120, 1'b0);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    send_random_frame(40, 1'b0);
    send_clear();
    send_random_frame(40, 1'b0);
  endtask

  // result side: check each transfer against the oldest expected report
  always @(posedge clk) begin : report_check
    frame_report_t want;
    if (out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: report with none expected: motion=%0b changed=%0d sampled=%0d",
                   $time, out_motion, out_changed_samples, out_sampled_count);
      end else begin
        want = expected_reports.pop_front();
        if (out_motion !== want.motion || out_changed_samples !== want.changed ||
            out_sampled_count !== want.sampled) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: report mismatch: expected motion=%0b changed=%0d sampled=%0d,",
                      " got motion=%0b changed=%0d sampled=%0d"},
                     $time, want.motion, want.changed, want.sampled,
                     out_motion, out_changed_samples, out_sampled_count);
        end
      end
    end
  end

  // result side: random stall after each transfer
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      ready_hold = receiver_stalls ? $urandom_range(0, 9) : 0;
      if (ready_hold != 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (ready_hold > 1) ready_hold--;
      else out_ready <= 1'b1;
    end
  end

  // test sequence
  initial begin
    clear_gray_ref();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_slot();
    test_clear_mid_frame();
    test_config_extremes();
    test_random_frames();
    test_long_frame();
    wait_idle();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
